// File: sv/pmst_pkg.sv
// Package for the Prim spanning tree block: default sizes, action codes, FSM states.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none
package pmst_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int ADDRESSABLE      = 32;

    localparam int IN_VERTEX_W  = 5;
    localparam int IN_WEIGHT_W  = 16;
    localparam int COUNT_W      = 6;
    localparam int COUNT_RESET  = 32;

    typedef enum logic [1:0] {
        ACT_STORE = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STORE2,
        S_PASS,
        S_DRAIN,
        S_ORD,
        S_OLD
    } t_state;

endpackage
`default_nettype wire

// File: sv/pmst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: sv/prim_minimum_spanning_tree.sv
// Prim minimum spanning tree over a dense adjacency matrix held in block RAM.
// Depends on pmst_pkg and pmst_ram (adjacency matrix and per-vertex node store).
//
//   channel   direction  handshake                 payload
//   in        to block   i_in_valid / o_in_stall   action, node_a, node_b, edge_weight
//   out       from block o_out_valid / i_out_stall lower/upper_vertex, tree_weight,
//                                                  reachable, last
//   cfg       to block   APB psel/penable/pready   vertex_count at paddr 0-3
//
// Store: one RAM write per direction. Clear: one matrix entry per cycle over all
// 4^ceil(log2(MAX_VERTICES)) entries (1024 by default); the same pass follows reset.
// Run with n vertices: up to n-1 scans of one matrix row (one adjacency and one node
// read per cycle), then one result per vertex 1 to n-1, waiting on out stalls.
// The input is stalled from acceptance until the last result is loaded.
`timescale 1ns / 1ps
`default_nettype none
module prim_minimum_spanning_tree
    import pmst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_action,
    input  wire logic [IN_VERTEX_W-1:0] i_node_a,
    input  wire logic [IN_VERTEX_W-1:0] i_node_b,
    input  wire logic [IN_WEIGHT_W-1:0] i_edge_weight,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [IN_VERTEX_W-1:0]      o_lower_vertex,
    output logic [IN_VERTEX_W-1:0]      o_upper_vertex,
    output logic [IN_WEIGHT_W-1:0]      o_tree_weight,
    output logic                        o_reachable,
    output logic                        o_last,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int KW     = WEIGHT_BITS + 1;
    localparam int NODE_W = 2 + VW + KW;
    localparam int ADJ_D  = 1 << (2 * VW);
    localparam int AW     = 2 * VW;
    localparam int LIM    = (MAX_VERTICES < ADDRESSABLE) ? MAX_VERTICES : ADDRESSABLE;
    localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    t_state r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic [AW-1:0]      r_clr;
    logic [VW-1:0]      r_a, r_b, r_p, r_j, r_jd, r_pass, r_last, r_v, r_pick, n_pick;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [KW-1:0]      r_low, n_low;
    logic               r_dv, r_first;

    logic               in_xfer, in_ok, cfg_wr;
    logic [VW-1:0]      a_idx, b_idx, nm1;
    logic               adj_we, node_we;
    logic [AW-1:0]      adj_waddr, adj_raddr;
    logic [KW-1:0]      adj_wdata, adj_rdata;
    logic [VW-1:0]      node_raddr;
    logic [NODE_W-1:0]  node_rdata, cur, upd;
    logic               out_free;

    assign pready  = 1'b1;
    assign prdata  = 32'(r_count);
    assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
    assign in_xfer = i_in_valid && !o_in_stall;
    assign a_idx   = VW'(i_node_a);
    assign b_idx   = VW'(i_node_b);
    assign in_ok   = (int'(i_node_a) < MAX_VERTICES) && (int'(i_node_b) < MAX_VERTICES);
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        if (r_count == '0) begin
            nm1 = '0;
        end else if (int'(r_count) > LIM) begin
            nm1 = VW'(LIM - 1);
        end else begin
            nm1 = VW'(r_count - 1'b1);
        end
    end

    pmst_ram #(.WIDTH(KW), .DEPTH(ADJ_D)) u_adj (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    pmst_ram #(.WIDTH(NODE_W), .DEPTH(1 << VW)) u_node (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(r_jd),
        .i_wdata(upd),
        .i_raddr(node_raddr),
        .o_rdata(node_rdata)
    );

    assign adj_raddr = {r_p, r_j};

    // relax one neighbor and track the next pick
    always_comb begin
        cur = r_first ? {1'b0, 1'b1, {VW{1'b0}}, KEY_INF} : node_rdata;
        if (r_first && r_jd == '0) begin
            cur[KW-1:0] = '0;
        end
        if (r_jd == r_p) begin
            cur[NODE_W-1] = 1'b1;
        end
        upd = cur;
        if (!cur[NODE_W-1] && !adj_rdata[WEIGHT_BITS] && adj_rdata < cur[KW-1:0]) begin
            upd = {1'b0, 1'b0, r_p, adj_rdata};
        end
        n_low  = r_low;
        n_pick = r_pick;
        if (r_dv && !upd[NODE_W-1] && upd[KW-1:0] < r_low) begin
            n_low  = upd[KW-1:0];
            n_pick = r_jd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == {AW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) begin
                    priority case (t_action'(i_action))
                        ACT_STORE: n_state = in_ok ? S_STORE2 : S_IDLE;
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_RUN:   n_state = (nm1 == '0) ? S_IDLE : S_PASS;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_STORE2: n_state = S_IDLE;
            S_PASS: begin
                if (r_j == r_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (n_low[WEIGHT_BITS] || r_pass == VW'(r_last - 1'b1)) begin
                    n_state = S_ORD;
                end else begin
                    n_state = S_PASS;
                end
            end
            S_ORD: begin
                if (out_free) n_state = S_OLD;
            end
            S_OLD: begin
                if (r_v == r_last) n_state = S_IDLE;
                else n_state = S_ORD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        node_we    = r_dv;
        node_raddr = (r_state == S_PASS) ? r_j : r_v;
        adj_we     = 1'b0;
        adj_waddr  = r_clr;
        adj_wdata  = KEY_INF;
        unique case (r_state)
            S_CLEAR: adj_we = 1'b1;
            S_IDLE: begin
                adj_we    = in_xfer && t_action'(i_action) == ACT_STORE && in_ok;
                adj_waddr = {a_idx, b_idx};
                adj_wdata = {1'b0, WEIGHT_BITS'(i_edge_weight)};
            end
            S_STORE2: begin
                adj_we    = 1'b1;
                adj_waddr = {r_b, r_a};
                adj_wdata = {1'b0, r_w};
            end
            default: adj_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= COUNT_W'(COUNT_RESET);
            r_dv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) r_count <= pwdata[COUNT_W-1:0];
            if (r_state == S_OLD) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            r_dv    <= (r_state == S_PASS);
            r_low   <= (r_state == S_IDLE || r_state == S_DRAIN) ? KEY_INF : n_low;
            r_pick  <= n_pick;
            r_jd    <= r_j;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_clr   <= '0;
                    r_a     <= a_idx;
                    r_b     <= b_idx;
                    r_w     <= WEIGHT_BITS'(i_edge_weight);
                    r_p     <= '0;
                    r_j     <= '0;
                    r_pass  <= '0;
                    r_first <= 1'b1;
                    r_last  <= nm1;
                end
                S_PASS: r_j <= r_j + 1'b1;
                S_DRAIN: begin
                    r_p     <= n_pick;
                    r_j     <= '0;
                    r_pass  <= r_pass + 1'b1;
                    r_first <= 1'b0;
                    r_v     <= VW'(1);
                end
                S_OLD: r_v <= r_v + 1'b1;
                default: r_j <= r_j;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OLD) begin
            o_last <= (r_v == r_last);
            if (node_rdata[NODE_W-2]) begin
                o_lower_vertex <= '0;
                o_upper_vertex <= IN_VERTEX_W'(r_v);
                o_tree_weight  <= '0;
                o_reachable    <= 1'b0;
            end else begin
                o_lower_vertex <= IN_VERTEX_W'((node_rdata[KW+VW-1:KW] < r_v) ?
                                               node_rdata[KW+VW-1:KW] : r_v);
                o_upper_vertex <= IN_VERTEX_W'((node_rdata[KW+VW-1:KW] < r_v) ?
                                               r_v : node_rdata[KW+VW-1:KW]);
                o_tree_weight  <= IN_WEIGHT_W'(node_rdata[WEIGHT_BITS-1:0]);
                o_reachable    <= 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pass_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |=> r_dv)
        else $error("row scan read without data stage");
    a_no_adj_write_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS || r_state == S_DRAIN || r_state == S_ORD || r_state == S_OLD)
        |-> !adj_we)
        else $error("matrix written during a run");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_jd <= r_last))
        else $error("scan past active vertex count");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLD && r_v == r_last) |=> (r_state == S_IDLE && o_out_valid && o_last))
        else $error("final result did not end the run");
`endif

endmodule
`default_nettype wire
